@@ sv/tlbpt_pkg.sv @@
`timescale 1ns / 1ps

package tlbpt_pkg;

  localparam int unsigned ADDR_BITS        = 16;
  localparam int unsigned OFFSET_BITS      = 8;
  localparam int unsigned PAGE_BITS        = ADDR_BITS - OFFSET_BITS;
  localparam int unsigned PAGE_COUNT       = 1 << PAGE_BITS;
  localparam int unsigned PA_BITS          = 15;
  localparam int unsigned STAMP_BITS       = 32;
  localparam int unsigned TLB_ENTRIES_DEF  = 16;
  localparam int unsigned FRAME_COUNT_DEF  = 128;
  localparam int unsigned IN_TDATA_BITS    = 16;
  localparam int unsigned OUT_TDATA_BITS   = 32;
  localparam int unsigned CFG_INDEX_BITS   = 1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TLB_USE_LRU   = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_USE_LRU = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FSCAN,
    ST_OWNER,
    ST_EVICT,
    ST_FILL,
    ST_TSCAN,
    ST_TWRITE,
    ST_STAMP
  } state_e;

  typedef struct packed {
    logic accept;
    logic resolve_hit;
    logic resolve_map;
    logic resolve_free;
    logic resolve_ring;
    logic fscan_start;
    logic fscan_step;
    logic evict;
    logic fill_first;
    logic fill_ring;
    logic tscan_start;
    logic tscan_step;
    logic fill_best;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic page_valid;
    logic free_avail;
    logic frame_lru;
    logic tlb_lru;
    logic has_invalid;
    logic fscan_last;
    logic tscan_last;
    logic out_free;
  } sts_t;

endpackage

@@ sv/tlbpt_ctrl.sv @@
`timescale 1ns / 1ps

module tlbpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tlbpt_pkg::sts_t   sts_i,
  output tlbpt_pkg::cmd_t   cmd_o
);

  tlbpt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlbpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tlbpt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tlbpt_pkg::ST_LOOKUP;
      end
      tlbpt_pkg::ST_LOOKUP: begin
        if (sts_i.hit) state_d = tlbpt_pkg::ST_STAMP;
        else if (sts_i.page_valid || sts_i.free_avail) state_d = tlbpt_pkg::ST_FILL;
        else if (!sts_i.frame_lru) state_d = tlbpt_pkg::ST_OWNER;
        else state_d = tlbpt_pkg::ST_FSCAN;
      end
      tlbpt_pkg::ST_FSCAN: begin
        if (sts_i.fscan_last) state_d = tlbpt_pkg::ST_OWNER;
      end
      tlbpt_pkg::ST_OWNER: state_d = tlbpt_pkg::ST_EVICT;
      tlbpt_pkg::ST_EVICT: state_d = tlbpt_pkg::ST_FILL;
      tlbpt_pkg::ST_FILL: begin
        if (!sts_i.tlb_lru || sts_i.has_invalid) state_d = tlbpt_pkg::ST_STAMP;
        else state_d = tlbpt_pkg::ST_TSCAN;
      end
      tlbpt_pkg::ST_TSCAN: begin
        if (sts_i.tscan_last) state_d = tlbpt_pkg::ST_TWRITE;
      end
      tlbpt_pkg::ST_TWRITE: state_d = tlbpt_pkg::ST_STAMP;
      tlbpt_pkg::ST_STAMP: begin
        if (sts_i.out_free) state_d = tlbpt_pkg::ST_IDLE;
      end
      default: state_d = tlbpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tlbpt_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      tlbpt_pkg::ST_LOOKUP: begin
        if (sts_i.hit) cmd_o.resolve_hit = 1'b1;
        else if (sts_i.page_valid) cmd_o.resolve_map = 1'b1;
        else if (sts_i.free_avail) cmd_o.resolve_free = 1'b1;
        else if (!sts_i.frame_lru) cmd_o.resolve_ring = 1'b1;
        else cmd_o.fscan_start = 1'b1;
      end
      tlbpt_pkg::ST_FSCAN: cmd_o.fscan_step = 1'b1;
      tlbpt_pkg::ST_EVICT: cmd_o.evict = 1'b1;
      tlbpt_pkg::ST_FILL: begin
        if (!sts_i.tlb_lru) cmd_o.fill_ring = 1'b1;
        else if (sts_i.has_invalid) cmd_o.fill_first = 1'b1;
        else cmd_o.tscan_start = 1'b1;
      end
      tlbpt_pkg::ST_TSCAN: cmd_o.tscan_step = 1'b1;
      tlbpt_pkg::ST_TWRITE: cmd_o.fill_best = 1'b1;
      tlbpt_pkg::ST_STAMP: cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ sv/tlbpt_dp.sv @@
`timescale 1ns / 1ps

module tlbpt_dp #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned FRAME_COUNT = tlbpt_pkg::FRAME_COUNT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tlbpt_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic                                  cfg_wdata_i,
  input  logic [tlbpt_pkg::ADDR_BITS-1:0]       in_addr_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [tlbpt_pkg::PA_BITS-1:0]         out_pa_o,
  output logic                                  out_hit_o,
  output logic                                  out_fault_o,
  output logic                                  out_evict_o,
  output logic [tlbpt_pkg::PAGE_BITS-1:0]       out_evicted_o,
  input  tlbpt_pkg::cmd_t                       cmd_i,
  output tlbpt_pkg::sts_t                       sts_o
);

  localparam int unsigned TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned PB = tlbpt_pkg::PAGE_BITS;
  localparam int unsigned OB = tlbpt_pkg::OFFSET_BITS;
  localparam int unsigned SB = tlbpt_pkg::STAMP_BITS;

  logic          tlb_lru_q, frame_lru_q;
  logic [SB-1:0] time_q;
  logic [PB-1:0] page_q;
  logic [OB-1:0] off_q;
  logic [FW-1:0] frame_q;
  logic [FW:0]   free_next_q;
  logic [FW-1:0] fring_q;
  logic [TW-1:0] tring_q;
  logic          hit_q, fault_q, evict_q;
  logic [TW-1:0] hidx_q;
  logic [PB-1:0] evicted_q;

  localparam int unsigned PAGE_COUNT_L = tlbpt_pkg::PAGE_COUNT;
  logic [PAGE_COUNT_L-1:0] pv_q;
  logic [FW-1:0] map_mem [PAGE_COUNT_L];
  logic [FW-1:0] map_rdata_q;
  logic [PB-1:0] own_mem [FRAME_COUNT];
  logic [PB-1:0] own_rdata_q;
  logic [SB-1:0] fst_mem [FRAME_COUNT];
  logic [SB-1:0] fst_rdata_q;

  logic [TLB_ENTRIES-1:0] tv_q;
  logic [PB-1:0]          tpage_q  [TLB_ENTRIES];
  logic [FW-1:0]          tframe_q [TLB_ENTRIES];
  logic [SB-1:0]          tstamp_q [TLB_ENTRIES];

  logic [FW:0]   fcnt_q;
  logic          fvld_q;
  logic [FW-1:0] fidx_q;
  logic [FW-1:0] fbest_q;
  logic [SB-1:0] fbstamp_q;
  logic [TW-1:0] tcnt_q;
  logic [TW-1:0] tbest_q;
  logic [SB-1:0] tbstamp_q;

  logic [PB-1:0] in_page;
  logic [PB-1:0] map_raddr;
  logic          match;
  logic [TW-1:0] match_idx;
  logic          has_inv;
  logic [TW-1:0] inv_idx;
  logic          fupd;
  logic [FW-1:0] fbest_n;
  logic          fissue;
  logic          fill_we;
  logic [TW-1:0] fill_slot;
  logic          out_valid_q;

  assign in_page   = in_addr_i[tlbpt_pkg::ADDR_BITS-1:OB];
  assign map_raddr = cmd_i.accept ? in_page : page_q;

  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tv_q[i] && tpage_q[i] == in_page) begin
        match     = 1'b1;
        match_idx = TW'(i);
      end
    end
  end

  always_comb begin
    has_inv = 1'b0;
    inv_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (!tv_q[i]) begin
        has_inv = 1'b1;
        inv_idx = TW'(i);
      end
    end
  end

  assign fissue  = cmd_i.fscan_step && (fcnt_q < (FW+1)'(FRAME_COUNT));
  assign fupd    = fvld_q && (fidx_q == '0 || fst_rdata_q < fbstamp_q);
  assign fbest_n = fupd ? fidx_q : fbest_q;

  assign fill_we   = cmd_i.fill_first || cmd_i.fill_ring || cmd_i.fill_best;
  assign fill_slot = cmd_i.fill_first ? inv_idx : (cmd_i.fill_ring ? tring_q : tbest_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_lru_q   <= 1'b1;
      frame_lru_q <= 1'b1;
      time_q      <= '0;
      free_next_q <= '0;
      fring_q     <= '0;
      tring_q     <= '0;
      pv_q        <= '0;
      tv_q        <= '0;
      fcnt_q      <= '0;
      fvld_q      <= 1'b0;
      tcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tlbpt_pkg::CFG_TLB_USE_LRU:   tlb_lru_q   <= cfg_wdata_i;
          tlbpt_pkg::CFG_FRAME_USE_LRU: frame_lru_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.accept && time_q != '1) time_q <= time_q + 1'b1;
      if (cmd_i.resolve_free) begin
        free_next_q              <= free_next_q + 1'b1;
        pv_q[page_q]             <= 1'b1;
      end
      if (cmd_i.resolve_ring) begin
        fring_q <= (fring_q == FW'(FRAME_COUNT - 1)) ? '0 : fring_q + 1'b1;
      end
      if (cmd_i.evict) begin
        pv_q[own_rdata_q] <= 1'b0;
        pv_q[page_q]      <= 1'b1;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (tv_q[i] && tpage_q[i] == own_rdata_q) tv_q[i] <= 1'b0;
        end
      end
      if (cmd_i.fill_ring) begin
        tring_q <= (tring_q == TW'(TLB_ENTRIES - 1)) ? '0 : tring_q + 1'b1;
      end
      if (fill_we) tv_q[fill_slot] <= 1'b1;
      if (cmd_i.fscan_start) begin
        fcnt_q <= '0;
        fvld_q <= 1'b0;
      end else if (cmd_i.fscan_step) begin
        fvld_q <= fissue;
        if (fissue) fcnt_q <= fcnt_q + 1'b1;
      end
      if (cmd_i.tscan_start) tcnt_q <= TW'(1);
      else if (cmd_i.tscan_step) tcnt_q <= tcnt_q + 1'b1;
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    map_rdata_q <= map_mem[map_raddr];
    if (cmd_i.resolve_free) map_mem[page_q] <= free_next_q[FW-1:0];
    if (cmd_i.evict) map_mem[page_q] <= frame_q;
  end

  always_ff @(posedge clk_i) begin
    own_rdata_q <= own_mem[frame_q];
    if (cmd_i.resolve_free) own_mem[free_next_q[FW-1:0]] <= page_q;
    if (cmd_i.evict) own_mem[frame_q] <= page_q;
  end

  always_ff @(posedge clk_i) begin
    fst_rdata_q <= fst_mem[fcnt_q[FW-1:0]];
    if (cmd_i.finish) fst_mem[frame_q] <= time_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q  <= in_page;
      off_q   <= in_addr_i[OB-1:0];
      hit_q   <= match;
      hidx_q  <= match_idx;
      fault_q <= 1'b0;
      evict_q <= 1'b0;
    end
    if (cmd_i.resolve_hit) begin
      frame_q          <= tframe_q[hidx_q];
      tstamp_q[hidx_q] <= time_q;
    end
    if (cmd_i.resolve_map) frame_q <= map_rdata_q;
    if (cmd_i.resolve_free) begin
      frame_q <= free_next_q[FW-1:0];
      fault_q <= 1'b1;
    end
    if (cmd_i.resolve_ring) begin
      frame_q <= fring_q;
      fault_q <= 1'b1;
    end
    if (cmd_i.fscan_start) fault_q <= 1'b1;
    if (cmd_i.fscan_step) begin
      fbest_q <= fbest_n;
      if (fupd) fbstamp_q <= fst_rdata_q;
      if (sts_o.fscan_last) frame_q <= fbest_n;
    end
    if (cmd_i.evict) begin
      evict_q   <= 1'b1;
      evicted_q <= own_rdata_q;
    end
    if (cmd_i.tscan_start) begin
      tbest_q   <= '0;
      tbstamp_q <= tstamp_q[0];
    end else if (cmd_i.tscan_step && tstamp_q[tcnt_q] < tbstamp_q) begin
      tbest_q   <= tcnt_q;
      tbstamp_q <= tstamp_q[tcnt_q];
    end
    if (fill_we) begin
      tpage_q[fill_slot]  <= page_q;
      tframe_q[fill_slot] <= frame_q;
      tstamp_q[fill_slot] <= time_q;
    end
  end

  logic [FW+OB-1:0] pa_full;
  logic [31:0]      pa_wide;

  assign pa_full = {frame_q, off_q};
  assign pa_wide = 32'(pa_full);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_pa_o      <= pa_wide[tlbpt_pkg::PA_BITS-1:0];
      out_hit_o     <= hit_q;
      out_fault_o   <= fault_q;
      out_evict_o   <= evict_q;
      out_evicted_o <= evict_q ? evicted_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o             = '0;
    sts_o.hit         = hit_q;
    sts_o.page_valid  = pv_q[page_q];
    sts_o.free_avail  = free_next_q < (FW+1)'(FRAME_COUNT);
    sts_o.frame_lru   = frame_lru_q;
    sts_o.tlb_lru     = tlb_lru_q;
    sts_o.has_invalid = has_inv;
    sts_o.fscan_last  = fvld_q && fidx_q == FW'(FRAME_COUNT - 1);
    sts_o.tscan_last  = tcnt_q == TW'(TLB_ENTRIES - 1);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (fissue) fidx_q <= fcnt_q[FW-1:0];
  end

  a_hit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_o && out_fault_o))
    else $error("TLB hit reported together with a page fault");
  a_evict_needs_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_evict_o |-> out_fault_o)
    else $error("Eviction reported without a page fault");
  a_evicted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_evict_o |-> out_evicted_o == '0)
    else $error("Evicted page not zero without an eviction");
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_next_q <= (FW+1)'(FRAME_COUNT))
    else $error("Free frame counter ran past the frame count");

endmodule

@@ sv/tlb_page_table_translator_unit.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Signals                       Payload
// s_axis    in         tvalid tready tdata[15:0]     virt_addr
// m_axis    out        tvalid tready tdata[31:0]     phys_addr, tlb_hit, page_fault,
//                                                    evict_valid, evicted_page
// cfg       in         cfg_we cfg_index cfg_wdata    0 tlb_use_lru, 1 frame_use_lru
//
// One transaction is handled at a time. A TLB hit, a miss on a mapped page and a fault with a
// free frame need no scan; LRU refill of a full TLB adds a scan over the TLB entry stamps,
// and a fault once all frames are used adds an owner lookup and eviction, preceded in LRU
// mode by a scan over the frame stamp memory, one entry per cycle.
// Reset clears the page valid bits and TLB valid bits at once; no clearing pass is needed.
// A finished result waits in the output register while the output is stalled.

module tlb_page_table_translator_unit #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned FRAME_COUNT = tlbpt_pkg::FRAME_COUNT_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [tlbpt_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic                                     cfg_wdata_i,
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // virt_addr[15:0]
  input  logic [tlbpt_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // phys_addr[14:0], tlb_hit[15], page_fault[16], evict_valid[17],
  // evicted_page[25:18], zero[31:26]
  output logic [tlbpt_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata_o
);

  tlbpt_pkg::cmd_t cmd;
  tlbpt_pkg::sts_t sts;

  logic [tlbpt_pkg::PA_BITS-1:0]   pa;
  logic                            hit, fault, evict;
  logic [tlbpt_pkg::PAGE_BITS-1:0] evicted;

  tlbpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tlbpt_dp #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_addr_i     (s_axis_tdata_i),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_pa_o      (pa),
    .out_hit_o     (hit),
    .out_fault_o   (fault),
    .out_evict_o   (evict),
    .out_evicted_o (evicted),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  assign m_axis_tdata_o = {6'd0, evicted, evict, fault, hit, pa};

endmodule

@@ tb/sv/tlb_page_table_translator_unit_tb.sv @@
`timescale 1ns / 1ps

module tlb_page_table_translator_unit_tb;

  localparam int unsigned NTLB = tlbpt_pkg::TLB_ENTRIES_DEF;
  localparam int unsigned NFRM = tlbpt_pkg::FRAME_COUNT_DEF;
  localparam int unsigned NPAGE = tlbpt_pkg::PAGE_COUNT;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [7:0]  evicted_page;
    logic        evict_valid;
    logic        page_fault;
    logic        tlb_hit;
    logic [14:0] phys_addr;
  } xlat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tlbpt_pkg::CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic cfg_wdata_i = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [tlbpt_pkg::IN_TDATA_BITS-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [tlbpt_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata_o;

  tlb_page_table_translator_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the translator state.
  logic        sh_tlb_lru, sh_frm_lru;
  logic        pg_valid [NPAGE];
  logic [6:0]  pg_frame [NPAGE];
  logic        tl_valid [NTLB];
  logic [7:0]  tl_page  [NTLB];
  logic [6:0]  tl_frame [NTLB];
  logic [31:0] tl_stamp [NTLB];
  logic [31:0] fr_stamp [NFRM];
  logic [31:0] now_stamp;
  int unsigned free_next;
  logic [3:0]  tlb_ring;
  logic [6:0]  frm_ring;

  xlat_t expected_xlats[$];
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  int unsigned hold_off = 0;
  int errors = 0;
  longint unsigned cycles = 0;

  function automatic xlat_t translate(logic [15:0] addr);
    xlat_t r;
    logic [7:0] page;
    logic [6:0] frame;
    int slot;
    logic found;
    page = addr[15:8];
    r = '0;
    frame = '0;
    if (now_stamp != 32'hFFFF_FFFF) now_stamp++;
    for (int i = 0; i < NTLB; i++) begin
      if (!r.tlb_hit && tl_valid[i] && tl_page[i] == page) begin
        tl_stamp[i] = now_stamp;
        frame = tl_frame[i];
        r.tlb_hit = 1'b1;
      end
    end
    if (!r.tlb_hit) begin
      if (pg_valid[page]) begin
        frame = pg_frame[page];
      end else begin
        r.page_fault = 1'b1;
        if (free_next < NFRM) begin
          frame = free_next[6:0];
          free_next++;
        end else begin
          if (!sh_frm_lru) begin
            frame = frm_ring;
            frm_ring = frm_ring + 7'd1;
          end else begin
            slot = 0;
            for (int i = 1; i < NFRM; i++) if (fr_stamp[i] < fr_stamp[slot]) slot = i;
            frame = slot[6:0];
          end
          for (int p = 0; p < NPAGE; p++) begin
            if (!r.evict_valid && pg_valid[p] && pg_frame[p] == frame) begin
              pg_valid[p] = 1'b0;
              for (int t = 0; t < NTLB; t++)
                if (tl_valid[t] && tl_page[t] == p) tl_valid[t] = 1'b0;
              r.evict_valid = 1'b1;
              r.evicted_page = p[7:0];
            end
          end
        end
        pg_valid[page] = 1'b1;
        pg_frame[page] = frame;
      end
      if (sh_tlb_lru) begin
        found = 1'b0;
        slot = 0;
        for (int i = 0; i < NTLB; i++) begin
          if (!found && !tl_valid[i]) begin
            slot = i;
            found = 1'b1;
          end
        end
        if (!found)
          for (int i = 1; i < NTLB; i++) if (tl_stamp[i] < tl_stamp[slot]) slot = i;
      end else begin
        slot = tlb_ring;
        tlb_ring = tlb_ring + 4'd1;
      end
      tl_valid[slot] = 1'b1;
      tl_page[slot] = page;
      tl_frame[slot] = frame;
      tl_stamp[slot] = now_stamp;
    end
    fr_stamp[frame] = now_stamp;
    r.phys_addr = {frame, addr[7:0]};
    return r;
  endfunction

  task automatic send_address(logic [15:0] addr);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= addr;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_xlats.push_back(translate(addr));
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_xlats.size() != 0) @(posedge clk_i);
    repeat (NFRM + NTLB + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tlbpt_pkg::CFG_INDEX_BITS-1:0] idx, logic val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tlbpt_pkg::CFG_TLB_USE_LRU) sh_tlb_lru = val;
    else sh_frm_lru = val;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        xlat_t got, exp_x;
        got = m_axis_tdata_o[25:0];
        if (expected_xlats.size() == 0) begin
          $error("unexpected transaction %h", m_axis_tdata_o);
          errors++;
        end else begin
          exp_x = expected_xlats.pop_front();
          if (got.phys_addr != exp_x.phys_addr) begin
            $error("phys_addr exp %h got %h", exp_x.phys_addr, got.phys_addr);
            errors++;
          end
          if (got.tlb_hit != exp_x.tlb_hit) begin
            $error("tlb_hit exp %b got %b", exp_x.tlb_hit, got.tlb_hit);
            errors++;
          end
          if (got.page_fault != exp_x.page_fault) begin
            $error("page_fault exp %b got %b", exp_x.page_fault, got.page_fault);
            errors++;
          end
          if (got.evict_valid != exp_x.evict_valid) begin
            $error("evict_valid exp %b got %b", exp_x.evict_valid, got.evict_valid);
            errors++;
          end
          if (got.evicted_page != exp_x.evicted_page) begin
            $error("evicted_page exp %h got %h", exp_x.evicted_page, got.evicted_page);
            errors++;
          end
        end
      end
      if (hold_off != 0) begin
        m_axis_tready_i <= 1'b0;
        hold_off--;
      end else begin
        m_axis_tready_i <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[tlb_page_table_translator_unit] ERROR");
      $finish;
    end
  end

  // Random page below span 80 percent of the time, so hits and refills mix.
  function automatic logic [15:0] rand_address(int unsigned span);
    logic [7:0] page;
    if ($urandom_range(99) < 80) page = 8'($urandom_range(span - 1));
    else page = 8'($urandom);
    return {page, 8'($urandom)};
  endfunction

  task automatic test_directed();
    send_address(16'h0000);
    send_address(16'hFFFF);
    send_address(16'h00FF);
    send_address(16'hFF00);
    send_address(16'h5AA5);
    send_address(16'hA55A);
    for (int p = 1; p <= 17; p++) send_address({p[7:0], 8'h3C});
    send_address(16'h0011);
  endtask

  task automatic test_fill_and_evict();
    for (int p = 0; p < 140; p++) send_address({p[7:0] ^ 8'h80, 8'($urandom)});
    for (int i = 0; i < 40; i++) send_address(rand_address(256));
  endtask

  task automatic test_random(int unsigned n);
    for (int i = 0; i < n; i++) send_address(rand_address($urandom_range(1) ? 24 : 200));
  endtask

  task automatic test_policies();
    write_reg(tlbpt_pkg::CFG_TLB_USE_LRU, 1'b0);
    test_random(150);
    write_reg(tlbpt_pkg::CFG_FRAME_USE_LRU, 1'b0);
    test_random(200);
    write_reg(tlbpt_pkg::CFG_TLB_USE_LRU, 1'b1);
    test_random(150);
    write_reg(tlbpt_pkg::CFG_FRAME_USE_LRU, 1'b1);
    test_random(150);
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 20; i++) send_address(rand_address(40));
    drain();
    for (int i = 0; i < 20; i++) send_address(rand_address(40));
  endtask

  initial begin
    sh_tlb_lru = 1'b1;
    sh_frm_lru = 1'b1;
    for (int i = 0; i < NPAGE; i++) begin
      pg_valid[i] = 1'b0;
      pg_frame[i] = '0;
    end
    for (int i = 0; i < NTLB; i++) begin
      tl_valid[i] = 1'b0;
      tl_page[i] = '0;
      tl_frame[i] = '0;
      tl_stamp[i] = '0;
    end
    for (int i = 0; i < NFRM; i++) fr_stamp[i] = '0;
    now_stamp = '0;
    free_next = 0;
    tlb_ring = '0;
    frm_ring = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 18;
    recv_idle_pct = 87;
    test_directed();
    test_fill_and_evict();
    test_random(200);
    send_idle_pct = 87;
    recv_idle_pct = 18;
    test_policies();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("[tlb_page_table_translator_unit] OK");
    end else begin
      $display("[tlb_page_table_translator_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/tlbpt_pkg.sv
sv/tlbpt_ctrl.sv
sv/tlbpt_dp.sv
sv/tlb_page_table_translator_unit.sv
tb/sv/tlb_page_table_translator_unit_tb.sv
